### hw/rtl/pjtb_pkg.sv
`default_nettype none

package pjtb_pkg;

    localparam int MAX_WORKERS_DEF = 16;

    localparam int OP_W       = 2;
    localparam int WID_W      = 4;
    localparam int PERIOD_W   = 16;
    localparam int KIND_W     = 3;
    localparam int SLOT_OUT_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_DONE = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DISPATCH  = 3'd0,
        KIND_ADDED     = 3'd1,
        KIND_COMPLETED = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_BAD_DONE  = 3'd4
    } kind_t;

    // One decoded command word passed from the front end to the executor.
    typedef struct packed {
        op_t                 op;
        logic [WID_W-1:0]    wid;
        logic [PERIOD_W-1:0] period;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE_WB
    } bstate_t;

endpackage

`default_nettype wire

### hw/rtl/periodic_job_timer_bank.sv
// Bank of periodic job timers. An add word claims the next free slot and
// reports its number (or table full); a tick word counts down every waiting
// slot from the newest to the oldest and reports each slot that expires as a
// dispatch word, the final one flagged with last; a done word rearms a busy
// slot or reports a bad done. A two-word input queue decouples the input from
// the executor. Add, bad done and table full are answered from the idle
// state; a good done reads the period store, then rearms the slot; a tick
// decodes, reads one slot at a time, evaluates each read, leaves the scan
// and flushes the held dispatch. Reads go through the single read port of
// the countdown store, which is visited at one slot per cycle while the
// output does not stall the scan.
`default_nettype none

module periodic_job_timer_bank
#(
    parameter int MAX_WORKERS = pjtb_pkg::MAX_WORKERS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [pjtb_pkg::OP_W-1:0]        op,
    input  wire logic [pjtb_pkg::WID_W-1:0]       worker_id,
    input  wire logic [pjtb_pkg::PERIOD_W-1:0]    period,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [pjtb_pkg::KIND_W-1:0]           kind,
    output logic [pjtb_pkg::SLOT_OUT_W-1:0]       slot,
    output logic                                  last
);
    import pjtb_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    pjtb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .worker_id (worker_id),
        .period    (period),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    pjtb_back
    #(
        .MAX_WORKERS (MAX_WORKERS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .slot      (slot),
        .last      (last)
    );

endmodule

`default_nettype wire

### hw/rtl/pjtb_front.sv
`default_nettype none

module pjtb_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [pjtb_pkg::OP_W-1:0]      op,
    input  wire logic [pjtb_pkg::WID_W-1:0]     worker_id,
    input  wire logic [pjtb_pkg::PERIOD_W-1:0]  period,
    output logic                                cmd_valid,
    output pjtb_pkg::cmd_t                      cmd,
    input  wire logic                           cmd_pop
);
    import pjtb_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       q_reg [DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       op_ok;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    assign in_stall  = (cnt_reg == 2'(DEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // The unused op code is accepted and dropped here.
    assign op_ok = (op == OP_TICK) || (op == OP_ADD) || (op == OP_DONE);
    assign push  = in_valid && !in_stall && op_ok;
    assign pop   = cmd_pop && cmd_valid;

    always_comb
    begin
        new_cmd.op     = op_t'(op);
        new_cmd.wid    = worker_id;
        new_cmd.period = (period == '0) ? PERIOD_W'(1) : period;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pjtb_back.sv
`default_nettype none

module pjtb_back
#(
    parameter int MAX_WORKERS = pjtb_pkg::MAX_WORKERS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    input  wire pjtb_pkg::cmd_t                   cmd,
    output logic                                  cmd_pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [pjtb_pkg::KIND_W-1:0]           kind,
    output logic [pjtb_pkg::SLOT_OUT_W-1:0]       slot,
    output logic                                  last
);
    import pjtb_pkg::*;

    localparam int SLOT_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W  = $clog2(MAX_WORKERS + 1);
    localparam int CMP_W  = (CNT_W > WID_W) ? CNT_W : WID_W;

    bstate_t state_reg, state_next;

    logic [CNT_W-1:0]       used_reg, used_next;
    logic [MAX_WORKERS-1:0] busy_reg, busy_next;
    logic [SLOT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                   scan_more_reg, scan_more_next;
    logic                   ev_v_reg, ev_v_next;
    logic [SLOT_W-1:0]      ev_idx_reg, ev_idx_next;
    logic                   pend_v_reg, pend_v_next;
    logic [SLOT_W-1:0]      pend_slot_reg, pend_slot_next;
    logic [SLOT_W-1:0]      wid_reg, wid_next;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [SLOT_OUT_W-1:0]  out_slot_reg, out_slot_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_load;

    // Countdown and period stores, one write and one registered read each.
    logic [PERIOD_W-1:0]    cnt_mem [MAX_WORKERS];
    logic [PERIOD_W-1:0]    per_mem [MAX_WORKERS];
    logic [PERIOD_W-1:0]    cnt_rd_reg;
    logic [PERIOD_W-1:0]    per_rd_reg;
    logic                   cnt_we, cnt_re, per_we, per_re;
    logic [SLOT_W-1:0]      cnt_wa, cnt_ra, per_wa, per_ra;
    logic [PERIOD_W-1:0]    cnt_wd, per_wd;

    logic                   out_free;
    logic                   full;
    logic                   wid_ok;
    logic [SLOT_W-1:0]      wid_idx;
    logic                   wid_good;
    logic                   advance;
    logic                   ev_busy;
    logic [PERIOD_W-1:0]    cnt_dec;
    logic                   ev_write;
    logic                   ev_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign full     = (used_reg == CNT_W'(MAX_WORKERS));
    assign wid_ok   = (CMP_W'(cmd.wid) < CMP_W'(used_reg));
    assign wid_idx  = SLOT_W'(cmd.wid);
    assign wid_good = wid_ok && busy_reg[wid_idx];

    // A found dispatch is held back in a pending register so the last one can be flagged.
    assign advance  = !ev_v_reg || !pend_v_reg || out_free;
    assign ev_busy  = busy_reg[ev_idx_reg];
    assign cnt_dec  = (cnt_rd_reg != '0) ? (cnt_rd_reg - PERIOD_W'(1)) : '0;
    assign ev_write = ev_v_reg && !ev_busy;
    assign ev_fire  = ev_write && (cnt_dec == '0);

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign slot      = out_slot_reg;
    assign last      = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.op == OP_TICK) && (used_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
                else if (cmd_valid && (cmd.op == OP_DONE) && wid_good)
                begin
                    state_next = ST_DONE_WB;
                end
            end
            ST_SCAN:
            begin
                if (!scan_more_reg && !ev_v_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_v_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE_WB:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop        = 1'b0;
        used_next      = used_reg;
        busy_next      = busy_reg;
        scan_idx_next  = scan_idx_reg;
        scan_more_next = scan_more_reg;
        ev_v_next      = ev_v_reg;
        ev_idx_next    = ev_idx_reg;
        pend_v_next    = pend_v_reg;
        pend_slot_next = pend_slot_reg;
        wid_next       = wid_reg;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;
        cnt_we         = 1'b0;
        cnt_wa         = ev_idx_reg;
        cnt_wd         = cnt_dec;
        cnt_re         = 1'b0;
        cnt_ra         = scan_idx_reg;
        per_we         = 1'b0;
        per_wa         = SLOT_W'(used_reg);
        per_wd         = cmd.period;
        per_re         = 1'b0;
        per_ra         = wid_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_TICK:
                        begin
                            cmd_pop = 1'b1;
                            if (used_reg != '0)
                            begin
                                scan_idx_next  = SLOT_W'(used_reg - CNT_W'(1));
                                scan_more_next = 1'b1;
                                ev_v_next      = 1'b0;
                            end
                        end
                        OP_ADD:
                        begin
                            if (out_free)
                            begin
                                cmd_pop       = 1'b1;
                                out_load      = 1'b1;
                                out_last_next = 1'b1;
                                if (full)
                                begin
                                    out_kind_next = KIND_FULL;
                                    out_slot_next = '0;
                                end
                                else
                                begin
                                    cnt_we    = 1'b1;
                                    cnt_wa    = SLOT_W'(used_reg);
                                    cnt_wd    = cmd.period;
                                    per_we    = 1'b1;
                                    busy_next[SLOT_W'(used_reg)] = 1'b0;
                                    used_next = used_reg + CNT_W'(1);
                                    out_kind_next = KIND_ADDED;
                                    out_slot_next = SLOT_OUT_W'(used_reg);
                                end
                            end
                        end
                        OP_DONE:
                        begin
                            if (wid_good)
                            begin
                                cmd_pop  = 1'b1;
                                per_re   = 1'b1;
                                wid_next = wid_idx;
                            end
                            else if (out_free)
                            begin
                                cmd_pop       = 1'b1;
                                out_load      = 1'b1;
                                out_kind_next = KIND_BAD_DONE;
                                out_slot_next = SLOT_OUT_W'(cmd.wid);
                                out_last_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    // Evaluate the slot read on the previous scan step.
                    if (ev_write)
                    begin
                        cnt_we = 1'b1;
                    end
                    if (ev_fire)
                    begin
                        busy_next[ev_idx_reg] = 1'b1;
                        if (pend_v_reg)
                        begin
                            out_load      = 1'b1;
                            out_kind_next = KIND_DISPATCH;
                            out_slot_next = SLOT_OUT_W'(pend_slot_reg);
                            out_last_next = 1'b0;
                        end
                        pend_v_next    = 1'b1;
                        pend_slot_next = ev_idx_reg;
                    end
                    // Read the next slot, walking down to slot zero.
                    if (scan_more_reg)
                    begin
                        cnt_re         = 1'b1;
                        ev_v_next      = 1'b1;
                        ev_idx_next    = scan_idx_reg;
                        scan_idx_next  = scan_idx_reg - SLOT_W'(1);
                        scan_more_next = (scan_idx_reg != '0);
                    end
                    else
                    begin
                        ev_v_next = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_v_reg && out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_DISPATCH;
                    out_slot_next = SLOT_OUT_W'(pend_slot_reg);
                    out_last_next = 1'b1;
                    pend_v_next   = 1'b0;
                end
            end
            ST_DONE_WB:
            begin
                if (out_free)
                begin
                    cnt_we             = 1'b1;
                    cnt_wa             = wid_reg;
                    cnt_wd             = per_rd_reg;
                    busy_next[wid_reg] = 1'b0;
                    out_load           = 1'b1;
                    out_kind_next      = KIND_COMPLETED;
                    out_slot_next      = SLOT_OUT_W'(wid_reg);
                    out_last_next      = 1'b1;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            busy_reg      <= '0;
            scan_more_reg <= 1'b0;
            ev_v_reg      <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            busy_reg      <= busy_next;
            scan_more_reg <= scan_more_next;
            ev_v_reg      <= ev_v_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        ev_idx_reg    <= ev_idx_next;
        pend_slot_reg <= pend_slot_next;
        wid_reg       <= wid_next;
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_slot_reg <= out_slot_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= cnt_mem[cnt_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            per_mem[per_wa] <= per_wd;
        end
        if (per_re)
        begin
            per_rd_reg <= per_mem[per_ra];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pjtb_checker.sv
`default_nettype none

module pjtb_checker
#(
    parameter int MAX_WORKERS = pjtb_pkg::MAX_WORKERS_DEF
)
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire logic [pjtb_pkg::OP_W-1:0]        op,
    input wire logic [pjtb_pkg::WID_W-1:0]       worker_id,
    input wire logic [pjtb_pkg::PERIOD_W-1:0]    period,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [pjtb_pkg::KIND_W-1:0]      kind,
    input wire logic [pjtb_pkg::SLOT_OUT_W-1:0]  slot,
    input wire logic                             last
);
    import pjtb_pkg::*;

    // A stalled input word holds still.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable({op, worker_id, period}))
        else $error("input word changed while stalled");

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({kind, slot, last}))
        else $error("result word changed while stalled");

    // Only a tick can give more than one word, so every other kind is final.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ADDED || kind == KIND_COMPLETED ||
                      kind == KIND_FULL || kind == KIND_BAD_DONE) |-> last)
        else $error("non-dispatch word without last");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_FULL) |-> (slot == '0))
        else $error("table full word with nonzero slot");

    a_added_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ADDED || kind == KIND_DISPATCH ||
                      kind == KIND_COMPLETED) |->
        (MAX_WORKERS > 16) || (int'(slot) < MAX_WORKERS))
        else $error("slot number beyond the bank");

endmodule

bind periodic_job_timer_bank pjtb_checker #(.MAX_WORKERS(MAX_WORKERS)) u_pjtb_checker (.*);

`default_nettype wire
